### design/heightfield_point_height_query_macros.svh
// assertion macros used by the design datapath
`ifndef HEIGHTFIELD_POINT_HEIGHT_QUERY_MACROS_SVH
`define HEIGHTFIELD_POINT_HEIGHT_QUERY_MACROS_SVH

`ifndef SYNTHESIS
`define HFQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hfq assertion failed");
`define HFQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfq assertion failed");
`else
`define HFQ_ASSERT(lbl, prop)
`define HFQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/hfq_pkg.sv
package hfq_pkg;

    localparam int SS_W        = 16;
    localparam int N_W         = 6;
    localparam int POS_W       = 24;
    localparam int LIM_W       = 22;
    localparam int Q_W         = 14;
    localparam int FRAC_W      = 8;
    localparam int W_W         = 9;
    localparam int ADDR_W      = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int OUT_W       = 16;
    localparam int LOAD_W      = 16;
    localparam int CNT_W       = 4;

    localparam int MAX_SQUARES = 63;
    localparam int HEIGHT_BITS = 16;
    localparam int N_LIMIT     = (MAX_SQUARES < 63) ? MAX_SQUARES : 63;

    localparam logic [SS_W-1:0] SS_RESET = 16'd256;
    localparam logic [N_W-1:0]  N_RESET  = 6'd63;

    localparam logic CFG_SQUARE_SIZE    = 1'b0;
    localparam logic CFG_SQUARES_IN_USE = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] SEL_H00    = 2'd0;
    localparam logic [1:0] SEL_H11    = 2'd1;
    localparam logic [1:0] SEL_CORNER = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       check;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       acc_first;
        logic       acc_add;
        logic [1:0] wsel;
        logic       out_load;
    } hfq_cmd_t;

    typedef struct packed {
        logic oor;
        logic div_done;
        logic out_free;
    } hfq_status_t;

endpackage

### design/hfq_div.sv
module hfq_div
    import hfq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LIM_W-1:0] pos,
    input  logic [SS_W-1:0]  divisor,
    output logic [Q_W-1:0]   quot,
    output logic             done
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SS_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]   low_reg, low_next;
    logic [SS_W:0]    trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, low_reg[Q_W-1]};
        ge        = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W - 1);
            rem_next  = pos[LIM_W-1:LIM_W-SS_W];
            low_next  = {pos[LIM_W-SS_W-1:0], {FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = ge ? SS_W'(trial - {1'b0, divisor}) : trial[SS_W-1:0];
            low_next = {low_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign quot = low_reg;
    assign done = !busy_reg;

endmodule

### design/hfq_ctrl.sv
module hfq_ctrl
    import hfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        kind,
    output logic        in_stall,
    input  hfq_status_t status,
    output hfq_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD0   = 3'd3;
    localparam logic [2:0] S_RD1   = 3'd4;
    localparam logic [2:0] S_RD2   = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && kind == KIND_QUERY)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.oor ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_H00;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = SEL_H11;
                cmd.acc_first = 1'b1;
                cmd.wsel      = SEL_H00;
                state_next    = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_CORNER;
                cmd.acc_add = 1'b1;
                cmd.wsel    = SEL_H11;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                cmd.wsel    = SEL_CORNER;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### design/hfq_datapath.sv
`include "heightfield_point_height_query_macros.svh"

module hfq_datapath
    import hfq_pkg::*;
#(
    parameter int HEIGHT_BITS = hfq_pkg::HEIGHT_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hfq_cmd_t          cmd,
    output hfq_status_t       status,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [SS_W-1:0]   cfg_data,
    input  logic              kind,
    input  logic [N_W-1:0]    grid_col,
    input  logic [N_W-1:0]    grid_row,
    input  logic [LOAD_W-1:0] load_height,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_z,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [OUT_W-1:0]  height,
    output logic              out_of_range
);

    localparam int PROD_W = HEIGHT_BITS + W_W;
    localparam int ACC_W  = (PROD_W > 24) ? PROD_W : 24;

    logic [SS_W-1:0]        ss_reg;
    logic [N_W-1:0]         sq_reg;
    logic [POS_W-1:0]       px_reg, pz_reg;
    logic                   oor_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [HEIGHT_BITS-1:0] rdata_reg;
    logic [HEIGHT_BITS-1:0] mem [STORE_DEPTH];
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       height_reg;
    logic                   oor_out_reg;

    logic [SS_W-1:0]        ss_eff;
    logic [N_W-1:0]         n_eff;
    logic [LIM_W-1:0]       lim;
    logic                   oor;
    logic [Q_W-1:0]         qx, qz;
    logic                   done_x, done_z, div_start;
    logic [N_W-1:0]         gx, gz, gx1, gz1;
    logic [N_W:0]           gx_inc, gz_inc;
    logic [FRAC_W-1:0]      fx, fz;
    logic                   upper;
    logic [N_W-1:0]         rd_col, rd_row;
    logic [W_W-1:0]         weight;
    logic [PROD_W-1:0]      prod;
    logic [ACC_W-1:0]       rounded;
    logic [HEIGHT_BITS+LOAD_W-1:0] load_ext;
    logic                   wr_en;

    always_comb
    begin
        ss_eff = (ss_reg == '0) ? SS_W'(1) : ss_reg;
        n_eff  = (sq_reg == '0) ? N_W'(1) : sq_reg;
        if (n_eff > N_W'(N_LIMIT))
        begin
            n_eff = N_W'(N_LIMIT);
        end
        lim = LIM_W'(n_eff) * LIM_W'(ss_eff);
        oor = px_reg[POS_W-1] || pz_reg[POS_W-1]
            || (px_reg[POS_W-2:0] > (POS_W-1)'(lim))
            || (pz_reg[POS_W-2:0] > (POS_W-1)'(lim));
    end

    assign div_start = cmd.check && !oor;

    hfq_div u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .pos     (px_reg[LIM_W-1:0]),
        .divisor (ss_eff),
        .quot    (qx),
        .done    (done_x)
    );

    hfq_div u_div_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .pos     (pz_reg[LIM_W-1:0]),
        .divisor (ss_eff),
        .quot    (qz),
        .done    (done_z)
    );

    always_comb
    begin
        gx     = qx[Q_W-1:FRAC_W];
        gz     = qz[Q_W-1:FRAC_W];
        fx     = qx[FRAC_W-1:0];
        fz     = qz[FRAC_W-1:0];
        upper  = (fx >= fz);
        gx_inc = {1'b0, gx} + 1'b1;
        gz_inc = {1'b0, gz} + 1'b1;
        gx1    = (gx_inc > {1'b0, n_eff}) ? '0 : gx_inc[N_W-1:0];
        gz1    = (gz_inc > {1'b0, n_eff}) ? '0 : gz_inc[N_W-1:0];
        rd_col = gx;
        rd_row = gz;
        unique case (cmd.rd_sel)
            SEL_H00:
            begin
                rd_col = gx;
                rd_row = gz;
            end
            SEL_H11:
            begin
                rd_col = gx1;
                rd_row = gz1;
            end
            SEL_CORNER:
            begin
                rd_col = upper ? gx1 : gx;
                rd_row = upper ? gz : gz1;
            end
            default:
            begin
                rd_col = gx;
                rd_row = gz;
            end
        endcase
        unique case (cmd.wsel)
            SEL_H00:    weight = upper ? (W_W'(256) - W_W'(fx)) : (W_W'(256) - W_W'(fz));
            SEL_H11:    weight = upper ? W_W'(fz) : W_W'(fx);
            SEL_CORNER: weight = upper ? W_W'(fx - fz) : W_W'(fz - fx);
            default:    weight = '0;
        endcase
        prod    = PROD_W'(weight) * PROD_W'(rdata_reg);
        rounded = acc_reg + ACC_W'(128);
    end

    // load beats write straight into the store
    assign load_ext = {{HEIGHT_BITS{1'b0}}, load_height};
    assign wr_en    = cmd.accept && (kind == KIND_LOAD);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{grid_row, grid_col}] <= load_ext[HEIGHT_BITS-1:0];
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[{rd_row, rd_col}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && kind == KIND_QUERY)
        begin
            px_reg <= pos_x;
            pz_reg <= pos_z;
        end
        if (cmd.check)
        begin
            oor_reg <= oor;
        end
        if (cmd.acc_first)
        begin
            acc_reg <= ACC_W'(prod);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (cmd.out_load)
        begin
            height_reg  <= oor_reg ? '0 : rounded[FRAC_W+OUT_W-1:FRAC_W];
            oor_out_reg <= oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg        <= SS_RESET;
            sq_reg        <= N_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_SQUARE_SIZE)
            begin
                ss_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_SQUARES_IN_USE)
            begin
                sq_reg <= cfg_data[N_W-1:0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.oor      = oor;
    assign status.div_done = done_x && done_z;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign height       = height_reg;
    assign out_of_range = oor_out_reg;

    `HFQ_ASSERT_NEXT(a_stalled_result_kept, out_valid_reg && out_stall, out_valid_reg)
    `HFQ_ASSERT(a_oor_height_zero, !(out_valid_reg && oor_out_reg && height_reg != '0))
    `HFQ_ASSERT(a_div_start_idle, !div_start || (done_x && done_z))

endmodule

### design/heightfield_point_height_query.sv
// height-field point query
// input channel: in_valid / in_stall, one beat per item. kind 0 loads one grid
// height (grid_col, grid_row, load_height), kind 1 queries the height at
// (pos_x, pos_z). loads give no result and leave the input free for the next item.
// output channel: out_valid / out_stall, one beat per query with height and
// out_of_range. a query in range runs 14 steps of the two parallel restoring
// dividers, then three reads of the single-port height store and the blend,
// before out_valid. an out-of-range query skips the dividers and the reads.
// one item is worked on at a time; in_stall is high while a query runs, so
// the next item is taken only once the query is done.
// a finished result waits in the output register while the next item is
// taken; a stalled result holds until taken and the next result then waits
// in the controller with in_stall high.
// config: cfg_valid / cfg_ready (always ready), cfg_index 0 square_size,
// 1 squares_in_use; write only while idle.
// reset: square_size 256, squares_in_use 63, no result pending; the height
// store is not cleared and every point must be loaded before it is queried.
module heightfield_point_height_query
    import hfq_pkg::*;
#(
    parameter int HEIGHT_BITS = hfq_pkg::HEIGHT_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [SS_W-1:0]   cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [N_W-1:0]    grid_col,
    input  logic [N_W-1:0]    grid_row,
    input  logic [LOAD_W-1:0] load_height,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_z,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  height,
    output logic              out_of_range
);

    hfq_cmd_t    cmd;
    hfq_status_t status;

    assign cfg_ready = 1'b1;

    hfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hfq_datapath #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .grid_col     (grid_col),
        .grid_row     (grid_row),
        .load_height  (load_height),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .height       (height),
        .out_of_range (out_of_range)
    );

endmodule

### tb/tb_heightfield_point_height_query.sv
`timescale 1ns / 1ps
module tb_heightfield_point_height_query;
    import hfq_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [N_W-1:0]    col;
        logic [N_W-1:0]    row;
        logic [LOAD_W-1:0] hgt;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  pz;
        logic              is_cfg;
        logic              cfg_idx;
        logic [SS_W-1:0]   cfg_val;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] hgt;
        logic             oor;
    } height_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [SS_W-1:0]   cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              kind;
    logic [N_W-1:0]    grid_col;
    logic [N_W-1:0]    grid_row;
    logic [LOAD_W-1:0] load_height;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_z;
    logic              out_valid;
    logic              out_stall;
    logic [OUT_W-1:0]  height;
    logic              out_of_range;

    heightfield_point_height_query u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .grid_col(grid_col), .grid_row(grid_row), .load_height(load_height),
        .pos_x(pos_x), .pos_z(pos_z),
        .out_valid(out_valid), .out_stall(out_stall), .height(height),
        .out_of_range(out_of_range)
    );

    item_t   pending_q[$];
    height_t heights_due_q[$];
    logic [15:0] grid_mem [0:4095];
    logic [SS_W-1:0] pred_ss;
    logic [N_W-1:0]  pred_n;
    int errors = 0;
    int n_queries = 0;
    int n_oor = 0;
    int n_cfg = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    int hold_off = 0;
    bit stimulus_done = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic height_t predict_height(input item_t it);
        height_t r;
        longint px, pz, ss, n, lim;
        int tx, tz, gx, gz, fx, fz, cx, cz;
        longint acc;
        longint h00, h10, h01, h11;
        px = longint'(signed'(it.px));
        pz = longint'(signed'(it.pz));
        ss = (pred_ss == 0) ? 1 : pred_ss;
        n = (pred_n == 0) ? 1 : pred_n;
        lim = n * ss;
        r = '0;
        if (px < 0 || pz < 0 || px > lim || pz > lim)
        begin
            r.oor = 1'b1;
            return r;
        end
        tx = int'((px * 256) / ss);
        tz = int'((pz * 256) / ss);
        gx = tx >> 8;
        gz = tz >> 8;
        fx = tx & 255;
        fz = tz & 255;
        cx = (gx + 1 > n) ? 0 : gx + 1;
        cz = (gz + 1 > n) ? 0 : gz + 1;
        h00 = grid_mem[gz * 64 + gx];
        h10 = grid_mem[gz * 64 + cx];
        h01 = grid_mem[cz * 64 + gx];
        h11 = grid_mem[cz * 64 + cx];
        if (fx >= fz)
            acc = (256 - fx) * h00 + (fx - fz) * h10 + fz * h11;
        else
            acc = (256 - fz) * h00 + fx * h11 + (fz - fx) * h01;
        r.hgt = 16'((acc + 128) >> 8);
        return r;
    endfunction

    function automatic item_t make_load(input int c, input int r, input logic [15:0] h);
        item_t it;
        it = '0;
        it.kind = KIND_LOAD;
        it.col = N_W'(c);
        it.row = N_W'(r);
        it.hgt = h;
        it.px = POS_W'($urandom);
        it.pz = POS_W'($urandom);
        return it;
    endfunction

    function automatic item_t make_query(input logic [23:0] x, input logic [23:0] z);
        item_t it;
        it = '0;
        it.kind = KIND_QUERY;
        it.px = x;
        it.pz = z;
        it.col = N_W'($urandom);
        it.row = N_W'($urandom);
        it.hgt = LOAD_W'($urandom);
        return it;
    endfunction

    function automatic item_t make_cfg(input logic idx, input logic [15:0] v);
        item_t it;
        it = '0;
        it.is_cfg = 1'b1;
        it.cfg_idx = idx;
        it.cfg_val = v;
        return it;
    endfunction

    function automatic logic [23:0] rand_in_range(input int n, input int ss);
        longint lim;
        lim = longint'(n) * ss;
        if (lim > 8388607)
            lim = 8388607;
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'(lim);
            default: return 24'($urandom_range(0, int'(lim)));
        endcase
    endfunction

    task automatic add_phase(input int n, input int ss, input int count);
        pending_q.push_back(make_cfg(CFG_SQUARE_SIZE, 16'(ss)));
        pending_q.push_back(make_cfg(CFG_SQUARES_IN_USE, 16'(n)));
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: pending_q.push_back(make_load($urandom, $urandom, 16'($urandom)));
                1: pending_q.push_back(make_query(24'($urandom), 24'($urandom)));
                default: pending_q.push_back(
                    make_query(rand_in_range(n, ss), rand_in_range(n, ss)));
            endcase
        end
    endtask

    initial
    begin
        // low 16x16 corner of the grid with extremes, plus points in the last two rows
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                pending_q.push_back(make_load(c, r,
                    ((r + c) % 3 == 0) ? 16'hffff :
                    ((r + c) % 3 == 1) ? 16'h0000 : 16'($urandom)));
        for (int r = 62; r < 64; r++)
        begin
            pending_q.push_back(make_load(0, r, 16'($urandom)));
            pending_q.push_back(make_load(62, r, 16'($urandom)));
            pending_q.push_back(make_load(63, r, 16'($urandom)));
        end
        pending_q.push_back(make_query(24'd0, 24'd0));
        pending_q.push_back(make_query(24'd16128, 24'd16128));
        pending_q.push_back(make_query(24'd16000, 24'd16127));
        pending_q.push_back(make_query(24'd16129, 24'd0));
        pending_q.push_back(make_query(24'hffffff, 24'd5));
        pending_q.push_back(make_query(24'd5, 24'h800000));
        pending_q.push_back(make_query(24'h7fffff, 24'h7fffff));
        pending_q.push_back(make_query(24'd300, 24'd100));
        pending_q.push_back(make_query(24'd100, 24'd300));
        pending_q.push_back(make_query(24'd3839, 24'd3000));
        add_phase(1, 1, 8);
        add_phase(0, 0, 8);
        add_phase(15, 65535, 30);
        add_phase(5, 100, 60);
        add_phase(15, 256, 60);
        add_phase(12, 3000, 60);
        add_phase(2, 65535, 40);
        add_phase(15, 1, 30);
        add_phase(9, 777, 40);
        stimulus_done = 1;
    end

    // driver
    int gap = 0;
    int pause = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            cfg_index <= CFG_SQUARE_SIZE;
            cfg_data <= '0;
            kind <= KIND_LOAD;
            grid_col <= '0;
            grid_row <= '0;
            load_height <= '0;
            pos_x <= '0;
            pos_z <= '0;
            gap <= 0;
            pause <= 0;
            quiet <= 1'b0;
            pred_ss = SS_RESET;
            pred_n = N_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_valid <= 1'b0;
                pause <= 40;
            end
            else if (in_valid && !in_stall)
            begin
                in_valid <= 1'b0;
                if (!quiet && $urandom_range(0, 5) == 0)
                    gap <= $urandom_range(1, 17);
            end
            else if (!in_valid && !cfg_valid)
            begin
                if (pause > 0)
                    pause <= pause - 1;
                else if (gap > 0)
                    gap <= gap - 1;
                else if (pending_q.size() > 0)
                begin
                    if (pending_q[0].is_cfg)
                    begin
                        if (heights_due_q.size() == 0 && !out_valid && idle_cycles > 30)
                        begin
                            item_t it;
                            it = pending_q.pop_front();
                            cfg_index <= it.cfg_idx;
                            cfg_data <= it.cfg_val;
                            cfg_valid <= 1'b1;
                            if (it.cfg_idx == CFG_SQUARE_SIZE)
                                pred_ss = it.cfg_val;
                            else
                                pred_n = it.cfg_val[N_W-1:0];
                            n_cfg++;
                        end
                    end
                    else
                    begin
                        item_t it;
                        it = pending_q.pop_front();
                        kind <= it.kind;
                        grid_col <= it.col;
                        grid_row <= it.row;
                        load_height <= it.hgt;
                        pos_x <= it.px;
                        pos_z <= it.pz;
                        in_valid <= 1'b1;
                        if (it.kind == KIND_LOAD)
                            grid_mem[it.row * 64 + it.col] = it.hgt;
                        else
                        begin
                            height_t e;
                            e = predict_height(it);
                            heights_due_q.push_back(e);
                            n_queries++;
                            if (e.oor)
                                n_oor++;
                        end
                    end
                end
            end
            quiet <= stimulus_done && pending_q.size() < 100;
        end
    end

    // monitor with receiver stalls
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (heights_due_q.size() == 0)
                begin
                    $display("unexpected result at %0t", $time);
                    errors++;
                end
                else
                begin
                    height_t e;
                    e = heights_due_q.pop_front();
                    if (height !== e.hgt)
                        report("height", 32'(height), 32'(e.hgt));
                    if (out_of_range !== e.oor)
                        report("out_of_range", 32'(out_of_range), 32'(e.oor));
                end
            end
            if (hold_off == 0 && n_queries == 100 && !quiet)
            begin
                hold_off <= 1;
                out_stall <= 1'b1;
                stall_left <= 600;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                stall_left <= $urandom_range(1, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // idle counter and watchdog
    int watchdog = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            watchdog <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            watchdog <= watchdog + 1;
            idle_cycles <= idle_cycles + 1;
        end
        if (watchdog > 5000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        wait (stimulus_done && pending_q.size() == 0 && !in_valid && !cfg_valid);
        wait (heights_due_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("covered %0d queries (%0d outside the grid) over %0d register writes",
            n_queries, n_oor, n_cfg);
        $display("grid loads, far-edge wrap, random stalls and one long output hold-off");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/hfq_pkg.sv
design/hfq_div.sv
design/hfq_ctrl.sv
design/hfq_datapath.sv
design/heightfield_point_height_query.sv
tb/tb_heightfield_point_height_query.sv
